@@ src/pptcr_pkg.sv @@
// ----------------------------------------------------------------------------
// pptcr_pkg
// Shared widths, codes, types and helper functions of the capture recorder.
// ----------------------------------------------------------------------------
package pptcr_pkg;

  localparam int DATA_W     = 32;
  localparam int DLY_DEPTH  = 1024;               // power of two, pointer wraps
  localparam int DLY_AW     = $clog2(DLY_DEPTH);
  localparam int SLOT_DEPTH = 2048;
  localparam int POS_W      = $clog2(SLOT_DEPTH);
  localparam int MAX_SLOTS  = 4;
  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int CAP_DEPTH  = MAX_SLOTS * SLOT_DEPTH;
  localparam int CAP_AW     = $clog2(CAP_DEPTH);

  localparam int PRE_W     = 10;
  localparam int POST_W    = 11;
  localparam int NSL_W     = 3;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 3;

  localparam logic [POS_W-1:0] CAP_MAX = POS_W'(SLOT_DEPTH - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRE    = 2'd0,
    CFG_POST   = 2'd1,
    CFG_NSLOTS = 2'd2
  } cfg_idx_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_SAMPLE  = 2'd0,
    ACT_READ    = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_IDLE     = 3'd0,
    ST_STORED   = 3'd1,
    ST_DONE     = 3'd2,
    ST_DROPPED  = 3'd3,
    ST_READ_OK  = 3'd4,
    ST_RELEASED = 3'd5,
    ST_NONE_RDY = 3'd6,
    ST_BAD_POS  = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } fsm_e;

  // Request to the delay line for one sample tick.
  typedef struct packed {
    logic              en;
    logic [PRE_W-1:0]  tap;
    logic [DATA_W-1:0] sample;
  } dly_req_t;

  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] data;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    logic              started;
  } result_t;

  // Slot count in use: zero acts as one, anything above the maximum saturates.
  function automatic logic [NSL_W-1:0] slots_eff(input logic [NSL_W-1:0] num);
    logic [NSL_W-1:0] r;
    r = num;
    if (num == '0) r = NSL_W'(1);
    else if (num > NSL_W'(MAX_SLOTS)) r = NSL_W'(MAX_SLOTS);
    return r;
  endfunction

  // Slot index modulo the count in use; the value never exceeds the maximum.
  function automatic logic [SLOT_W-1:0] slot_mod(input logic [NSL_W-1:0] v,
                                                 input logic [NSL_W-1:0] n);
    logic [NSL_W-1:0] r;
    r = v;
    for (int k = 0; k < MAX_SLOTS; k++) begin
      if (r >= n) r = r - n;
    end
    return r[SLOT_W-1:0];
  endfunction

  // Capture length, saturated to CAP_MAX, one below the slot size.
  function automatic logic [POS_W-1:0] cap_len(input logic [PRE_W-1:0] pre,
                                               input logic [POST_W-1:0] post);
    logic [POS_W:0] sum;
    sum = (POS_W+1)'(pre) + (POS_W+1)'(post);
    if (sum > (POS_W+1)'(CAP_MAX)) return CAP_MAX;
    return sum[POS_W-1:0];
  endfunction

endpackage

@@ src/pptcr_if.sv @@
// ----------------------------------------------------------------------------
// pptcr_in_if / pptcr_out_if
// Valid/ready channels carrying requests into and results out of the recorder.
// ----------------------------------------------------------------------------
interface pptcr_in_if;
  logic                        valid;
  logic                        ready;
  logic [pptcr_pkg::ACT_W-1:0] action;
  logic [pptcr_pkg::DATA_W-1:0] sample;
  logic                        trigger;
  logic [pptcr_pkg::POS_W-1:0] read_pos;

  modport source (output valid, action, sample, trigger, read_pos, input ready);
  modport sink   (input valid, action, sample, trigger, read_pos, output ready);
endinterface

interface pptcr_out_if;
  logic                         valid;
  logic                         ready;
  logic [pptcr_pkg::STAT_W-1:0] status;
  logic [pptcr_pkg::DATA_W-1:0] read_data;
  logic [pptcr_pkg::SLOT_W-1:0] slot;
  logic [pptcr_pkg::POS_W-1:0]  position;
  logic                         capture_started;

  modport source (output valid, status, read_data, slot, position, capture_started,
                  input ready);
  modport sink   (input valid, status, read_data, slot, position, capture_started,
                  output ready);
endinterface

@@ src/pre_post_trigger_capture_recorder.sv @@
// ----------------------------------------------------------------------------
// pre_post_trigger_capture_recorder
// Disturbance recorder with a pre-trigger delay line and a ring of capture
// slots.
// ----------------------------------------------------------------------------
// Requests enter on in_i and each gives exactly one result on out_o.
// A sample tick pushes the sample through the delay line and, while a capture
// runs, stores the delayed word in the current fill slot. A rising trigger
// edge with no capture running arms a new one. Read requests fetch a word
// from the oldest ready slot, release requests free that slot.
// A request is taken in idle, latching it and reading the delay-line and
// capture memories, then finishes in execute, using the registered read data
// to write results back. Only then is the next request taken.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, a second finished request holds in the
// execute cycle and in_i.ready stays low until the output register frees.
// Reset clears the control state and the configuration to its defaults; the
// delay line reads as zero until written, with no clearing pass. The capture
// store is undefined until written. The user must write configuration through
// cfg_we_i/cfg_idx_i/cfg_wdata_i while the recorder is idle; it is unchecked.
// ----------------------------------------------------------------------------
module pre_post_trigger_capture_recorder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pptcr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pptcr_pkg::CFG_W-1:0]     cfg_wdata_i,
  pptcr_in_if.sink                       in_i,
  pptcr_out_if.source                    out_o
);

  pptcr_pkg::fsm_e st_q, st_d;

  logic [pptcr_pkg::PRE_W-1:0]  pre_q;
  logic [pptcr_pkg::POST_W-1:0] post_q;
  logic [pptcr_pkg::NSL_W-1:0]  nsl_q;

  pptcr_pkg::action_e           act_q, act_d;
  logic                         trig_q, trig_d;
  logic [pptcr_pkg::POS_W-1:0]  rpos_q, rpos_d;

  logic [pptcr_pkg::POS_W-1:0]     rem_q, rem_d;
  logic [pptcr_pkg::SLOT_W-1:0]    fill_q, fill_d;
  logic [pptcr_pkg::SLOT_W-1:0]    save_q, save_d;
  logic [pptcr_pkg::MAX_SLOTS-1:0] rdy_q, rdy_d;
  logic                            prev_q, prev_d;

  logic                 ov_q, ov_d;
  pptcr_pkg::result_t   res_q, res_d, res;

  logic                           accept, done;
  logic [pptcr_pkg::NSL_W-1:0]    n_eff;
  logic [pptcr_pkg::POS_W-1:0]    total;
  logic [pptcr_pkg::SLOT_W-1:0]   fill_s, save_s;
  pptcr_pkg::dly_req_t            dly_req;
  logic [pptcr_pkg::DATA_W-1:0]   delayed;
  logic                           cap_we, cap_re;
  logic [pptcr_pkg::CAP_AW-1:0]   cap_waddr, cap_raddr;
  logic [pptcr_pkg::DATA_W-1:0]   cap_rdata;
  logic [pptcr_pkg::POS_W-1:0]    rem_dec, pos_w;

  assign n_eff  = pptcr_pkg::slots_eff(nsl_q);
  assign total  = pptcr_pkg::cap_len(pre_q, post_q);
  assign fill_s = pptcr_pkg::slot_mod(pptcr_pkg::NSL_W'(fill_q), n_eff);
  assign save_s = pptcr_pkg::slot_mod(pptcr_pkg::NSL_W'(save_q), n_eff);

  assign in_i.ready = (st_q == pptcr_pkg::S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign done       = (st_q == pptcr_pkg::S_EXEC) && (!ov_q || out_o.ready);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q  <= '0;
      post_q <= pptcr_pkg::POST_W'(1);
      nsl_q  <= pptcr_pkg::NSL_W'(pptcr_pkg::MAX_SLOTS);
    end else if (cfg_we_i) begin
      case (pptcr_pkg::cfg_idx_e'(cfg_idx_i))
        pptcr_pkg::CFG_PRE:    pre_q  <= cfg_wdata_i[pptcr_pkg::PRE_W-1:0];
        pptcr_pkg::CFG_POST:   post_q <= cfg_wdata_i[pptcr_pkg::POST_W-1:0];
        pptcr_pkg::CFG_NSLOTS: nsl_q  <= cfg_wdata_i[pptcr_pkg::NSL_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept stage: latch the request and issue memory reads.
  always_comb begin
    act_d  = act_q;
    trig_d = trig_q;
    rpos_d = rpos_q;
    if (accept) begin
      act_d  = pptcr_pkg::action_e'(in_i.action);
      trig_d = in_i.trigger;
      rpos_d = in_i.read_pos;
    end
  end

  assign dly_req.en     = accept && (pptcr_pkg::action_e'(in_i.action) == pptcr_pkg::ACT_SAMPLE);
  assign dly_req.tap    = pre_q;
  assign dly_req.sample = in_i.sample;

  assign cap_re    = accept && (pptcr_pkg::action_e'(in_i.action) == pptcr_pkg::ACT_READ);
  assign cap_raddr = {save_s, in_i.read_pos};

  // Execute stage: use the read data and update the control state.
  assign rem_dec = (rem_q != '0) ? rem_q - 1'b1 : '0;
  assign pos_w   = (total > rem_dec) ? total - rem_dec - 1'b1 : '0;

  always_comb begin
    rem_d     = rem_q;
    fill_d    = fill_q;
    save_d    = save_q;
    rdy_d     = rdy_q;
    prev_d    = prev_q;
    cap_we    = 1'b0;
    cap_waddr = {fill_s, pos_w};
    res       = '{status: pptcr_pkg::ST_IDLE, data: '0, slot: '0, pos: '0, started: 1'b0};
    case (act_q)
      pptcr_pkg::ACT_SAMPLE: begin
        if (rem_q != '0) begin
          rem_d    = rem_dec;
          res.slot = fill_s;
          res.pos  = pos_w;
          if (!rdy_q[fill_s]) begin
            cap_we     = done;
            res.status = pptcr_pkg::ST_STORED;
            if (rem_dec == '0) begin
              rdy_d[fill_s] = 1'b1;
              fill_d = pptcr_pkg::slot_mod(pptcr_pkg::NSL_W'(fill_s) + 1'b1, n_eff);
              res.status = pptcr_pkg::ST_DONE;
            end
          end else begin
            res.status = pptcr_pkg::ST_DROPPED;
          end
        end
        if (trig_q && !prev_q && rem_dec == '0) begin
          rem_d       = total;
          res.started = (total != '0);
        end
        prev_d = trig_q;
      end
      pptcr_pkg::ACT_READ: begin
        res.slot = save_s;
        if (!rdy_q[save_s]) begin
          res.status = pptcr_pkg::ST_NONE_RDY;
        end else if (rpos_q >= total) begin
          res.status = pptcr_pkg::ST_BAD_POS;
          res.pos    = rpos_q;
        end else begin
          res.status = pptcr_pkg::ST_READ_OK;
          res.pos    = rpos_q;
          res.data   = cap_rdata;
        end
      end
      pptcr_pkg::ACT_RELEASE: begin
        res.slot = save_s;
        if (rdy_q[save_s]) begin
          rdy_d[save_s] = 1'b0;
          save_d = pptcr_pkg::slot_mod(pptcr_pkg::NSL_W'(save_s) + 1'b1, n_eff);
          res.status = pptcr_pkg::ST_RELEASED;
        end else begin
          res.status = pptcr_pkg::ST_NONE_RDY;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    st_d  = st_q;
    ov_d  = ov_q;
    res_d = res_q;
    if (out_o.ready) ov_d = 1'b0;
    case (st_q)
      pptcr_pkg::S_IDLE: if (accept) st_d = pptcr_pkg::S_EXEC;
      pptcr_pkg::S_EXEC: begin
        if (done) begin
          st_d  = pptcr_pkg::S_IDLE;
          ov_d  = 1'b1;
          res_d = res;
        end
      end
      default: st_d = pptcr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= pptcr_pkg::S_IDLE;
      ov_q   <= 1'b0;
      act_q  <= pptcr_pkg::ACT_NONE;
      rem_q  <= '0;
      fill_q <= '0;
      save_q <= '0;
      rdy_q  <= '0;
      prev_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      ov_q  <= ov_d;
      act_q <= act_d;
      if (done) begin
        rem_q  <= rem_d;
        fill_q <= fill_d;
        save_q <= save_d;
        rdy_q  <= rdy_d;
        prev_q <= prev_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    trig_q <= trig_d;
    rpos_q <= rpos_d;
    res_q  <= res_d;
  end

  pptcr_delay u_delay (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (dly_req),
    .delayed_o (delayed)
  );

  pptcr_ram #(
    .WIDTH (pptcr_pkg::DATA_W),
    .DEPTH (pptcr_pkg::CAP_DEPTH)
  ) u_cap_ram (
    .clk_i   (clk_i),
    .we_i    (cap_we),
    .waddr_i (cap_waddr),
    .wdata_i (delayed),
    .re_i    (cap_re),
    .raddr_i (cap_raddr),
    .rdata_o (cap_rdata)
  );

  assign out_o.valid           = ov_q;
  assign out_o.status          = res_q.status;
  assign out_o.read_data       = res_q.data;
  assign out_o.slot            = res_q.slot;
  assign out_o.position        = res_q.pos;
  assign out_o.capture_started = res_q.started;

`ifndef NO_ASSERTIONS
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (st_q == pptcr_pkg::S_EXEC))
    else $error("accepted request did not enter execute");

  a_write_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_we |-> (!rdy_q[fill_s] && done))
    else $error("capture write into a ready slot");

  a_done_sets_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_we && res.status == pptcr_pkg::ST_DONE) |=> rdy_q[$past(fill_s)])
    else $error("finished slot not marked ready");

  a_out_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(st_q == pptcr_pkg::S_EXEC))
    else $error("result appeared without an execute cycle");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q <= pptcr_pkg::CAP_MAX) && !(accept && st_q == pptcr_pkg::S_EXEC))
    else $error("countdown out of range or overlapping requests");
`endif

endmodule

@@ src/pptcr_ram.sv @@
// ----------------------------------------------------------------------------
// pptcr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pptcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/pptcr_delay.sv @@
// ----------------------------------------------------------------------------
// pptcr_delay
// Pre-trigger delay line: writes each sample and returns the tapped word in the
// cycle after the request. The word stays valid until the next request.
// ----------------------------------------------------------------------------
module pptcr_delay (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pptcr_pkg::dly_req_t         req_i,
  output logic [pptcr_pkg::DATA_W-1:0] delayed_o
);

  logic [pptcr_pkg::DLY_AW-1:0] ptr_q, ptr_d;
  logic                         wrap_q, wrap_d;
  logic                         ok_q, ok_d;
  logic                         byp_q, byp_d;
  logic [pptcr_pkg::DATA_W-1:0] samp_q, samp_d;
  logic [pptcr_pkg::DLY_AW-1:0] rd_idx;
  logic [pptcr_pkg::DATA_W-1:0] rdata;

  // Entries that were never written since reset read as zero. Writes go in
  // pointer order, so an entry is written once the pointer has passed it.
  assign rd_idx = ptr_q - pptcr_pkg::DLY_AW'(req_i.tap);

  always_comb begin
    ptr_d  = ptr_q;
    wrap_d = wrap_q;
    ok_d   = ok_q;
    byp_d  = byp_q;
    samp_d = samp_q;
    if (req_i.en) begin
      ptr_d  = ptr_q + 1'b1;
      if (ptr_q == pptcr_pkg::DLY_AW'(pptcr_pkg::DLY_DEPTH - 1)) wrap_d = 1'b1;
      ok_d   = wrap_q || (rd_idx < ptr_q);
      byp_d  = (req_i.tap == '0);
      samp_d = req_i.sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      wrap_q <= 1'b0;
      ok_q   <= 1'b0;
      byp_q  <= 1'b0;
    end else begin
      ptr_q  <= ptr_d;
      wrap_q <= wrap_d;
      ok_q   <= ok_d;
      byp_q  <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q <= samp_d;
  end

  pptcr_ram #(
    .WIDTH (pptcr_pkg::DATA_W),
    .DEPTH (pptcr_pkg::DLY_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.en),
    .waddr_i (ptr_q),
    .wdata_i (req_i.sample),
    .re_i    (req_i.en),
    .raddr_i (rd_idx),
    .rdata_o (rdata)
  );

  assign delayed_o = byp_q ? samp_q : (ok_q ? rdata : '0);

endmodule
